FILE: src/mtc_pkg.sv
package mtc_pkg;

  localparam int LATTICE_SIZE = 64;
  localparam int COORD_W      = 6;
  localparam int VERT_W       = 7;
  localparam int NUM_TET      = 6;
  localparam int NUM_SLOT     = 2 * NUM_TET;
  localparam int SLOT_W       = $clog2(NUM_SLOT);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] CODE_EMPTY = 4'h0;
  localparam logic [3:0] CODE_FULL  = 4'hf;

  // corners a,b,c,d of each tetrahedron, corner number dx + 2*dy + 4*dz
  localparam logic [2:0] TET_DEF [NUM_TET][4] = '{
    '{3'd2, 3'd0, 3'd4, 3'd5},
    '{3'd2, 3'd0, 3'd1, 3'd5},
    '{3'd2, 3'd6, 3'd4, 3'd5},
    '{3'd2, 3'd6, 3'd7, 3'd5},
    '{3'd2, 3'd3, 3'd1, 3'd5},
    '{3'd2, 3'd3, 3'd7, 3'd5}
  };

  localparam logic TET_REFL [NUM_TET] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  localparam logic [1:0] EDGE_ENDS [6][2] = '{
    '{2'd0, 2'd1}, '{2'd1, 2'd2}, '{2'd2, 2'd0},
    '{2'd0, 2'd3}, '{2'd1, 2'd3}, '{2'd2, 2'd3}
  };

  localparam logic [1:0] CASE_COUNT [16] = '{
    2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1,
    2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0
  };

  localparam logic [2:0] CASE_TRIS [16][2][3] = '{
    '{'{3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0}},
    '{'{3'd3, 3'd5, 3'd4}, '{3'd0, 3'd0, 3'd0}},
    '{'{3'd2, 3'd1, 3'd5}, '{3'd0, 3'd0, 3'd0}},
    '{'{3'd3, 3'd2, 3'd1}, '{3'd3, 3'd1, 3'd4}},
    '{'{3'd0, 3'd4, 3'd1}, '{3'd0, 3'd0, 3'd0}},
    '{'{3'd0, 3'd3, 3'd5}, '{3'd0, 3'd5, 3'd1}},
    '{'{3'd2, 3'd0, 3'd4}, '{3'd2, 3'd4, 3'd5}},
    '{'{3'd2, 3'd0, 3'd3}, '{3'd0, 3'd0, 3'd0}},
    '{'{3'd3, 3'd0, 3'd2}, '{3'd0, 3'd0, 3'd0}},
    '{'{3'd0, 3'd2, 3'd5}, '{3'd0, 3'd5, 3'd4}},
    '{'{3'd3, 3'd0, 3'd1}, '{3'd3, 3'd1, 3'd5}},
    '{'{3'd0, 3'd1, 3'd4}, '{3'd0, 3'd0, 3'd0}},
    '{'{3'd2, 3'd3, 3'd4}, '{3'd2, 3'd4, 3'd1}},
    '{'{3'd2, 3'd5, 3'd1}, '{3'd0, 3'd0, 3'd0}},
    '{'{3'd3, 3'd4, 3'd5}, '{3'd0, 3'd0, 3'd0}},
    '{'{3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0}}
  };

  // one classified cell: base corner, per-tetrahedron case codes, triangle slots
  typedef struct packed {
    logic [COORD_W-1:0]          base_x;
    logic [COORD_W-1:0]          base_y;
    logic [COORD_W-1:0]          base_z;
    logic [NUM_TET-1:0][3:0]     codes;
    logic [NUM_SLOT-1:0]         slots;
  } mtc_job_t;

endpackage

FILE: src/mtc_front.sv
module mtc_front
  import mtc_pkg::*;
(
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cell_x, cell_y, cell_z, corner_bits, zero pad
  input  logic        q_full,
  output logic        q_push,
  output mtc_job_t    q_job
);

  logic [COORD_W-1:0] cell_x, cell_y, cell_z;
  logic [7:0]         corner_bits;
  logic               in_lattice;

  assign cell_x      = in_tdata[5:0];
  assign cell_y      = in_tdata[11:6];
  assign cell_z      = in_tdata[17:12];
  assign corner_bits = in_tdata[25:18];

  assign in_lattice = ((int'(cell_x) + 1) < LATTICE_SIZE) &&
                      ((int'(cell_y) + 1) < LATTICE_SIZE) &&
                      ((int'(cell_z) + 1) < LATTICE_SIZE);

  always_comb begin
    logic [3:0] code;
    q_job        = '0;
    q_job.base_x = cell_x;
    q_job.base_y = cell_y;
    q_job.base_z = cell_z;
    for (int t = 0; t < NUM_TET; t++) begin
      for (int j = 0; j < 4; j++) begin
        code[3-j] = corner_bits[TET_DEF[t][j]];
      end
      if (TET_REFL[t]) begin
        code = code ^ CODE_FULL;
      end
      q_job.codes[t]       = code;
      q_job.slots[2*t]     = (CASE_COUNT[code] != 2'd0);
      q_job.slots[2*t + 1] = (CASE_COUNT[code] == 2'd2);
    end
  end

  assign in_tready = !q_full;
  // drop cells outside the lattice and cells with no crossing
  assign q_push = in_tvalid && in_tready && in_lattice && (q_job.slots != '0);

endmodule

FILE: src/mtc_queue.sv
module mtc_queue
  import mtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mtc_job_t wr_job,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output mtc_job_t rd_job
);

  mtc_job_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full   = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid  = (cnt_r != '0);
  assign rd_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

FILE: src/mtc_back.sv
module mtc_back
  import mtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  mtc_job_t    q_job,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, pad
  output logic        out_tlast   // last_triangle
);

  mtc_job_t             cur_r, cur_nxt;
  logic [NUM_SLOT-1:0]  mask_r, mask_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_tlast_r, out_tlast_nxt;
  logic [62:0]          out_data_r, out_data_nxt;

  logic                 adv, have, emit, last, load;
  logic [SLOT_W-1:0]    sel;
  logic [NUM_SLOT-1:0]  rest;
  logic [2:0]           tet;
  logic                 tri_i;
  logic [3:0]           code;
  logic [62:0]          tri_data;

  // lowest pending triangle slot
  always_comb begin
    sel = '0;
    for (int s = NUM_SLOT - 1; s >= 0; s--) begin
      if (mask_r[s]) begin
        sel = SLOT_W'(s);
      end
    end
  end

  assign rest  = mask_r & (mask_r - NUM_SLOT'(1));
  assign last  = (rest == '0);
  assign tet   = sel[SLOT_W-1:1];
  assign tri_i = sel[0];
  assign code  = cur_r.codes[tet];

  always_comb begin
    logic [2:0]           e;
    logic [2:0]           ca, cb;
    logic [COORD_W-1:0]   b;
    for (int v = 0; v < 3; v++) begin
      e  = CASE_TRIS[code][tri_i][v];
      ca = TET_DEF[tet][EDGE_ENDS[e][0]];
      cb = TET_DEF[tet][EDGE_ENDS[e][1]];
      for (int ax = 0; ax < 3; ax++) begin
        case (ax)
          0:       b = cur_r.base_x;
          1:       b = cur_r.base_y;
          default: b = cur_r.base_z;
        endcase
        tri_data[(3*v + ax)*VERT_W +: VERT_W] =
          {b, 1'b0} + {{(VERT_W-1){1'b0}}, ca[ax]} + {{(VERT_W-1){1'b0}}, cb[ax]};
      end
    end
  end

  assign adv   = !out_tvalid_r || out_tready;
  assign have  = (mask_r != '0);
  assign emit  = adv && have;
  assign load  = q_valid && (!have || (emit && last));
  assign q_pop = load;

  always_comb begin
    cur_nxt        = cur_r;
    mask_nxt       = mask_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tlast_nxt  = out_tlast_r;
    out_data_nxt   = out_data_r;
    if (adv) begin
      out_tvalid_nxt = have;
    end
    if (emit) begin
      out_tlast_nxt = last;
      out_data_nxt  = tri_data;
      mask_nxt      = rest;
    end
    if (load) begin
      cur_nxt  = q_job;
      mask_nxt = q_job.slots;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      mask_r       <= mask_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = {1'b0, out_data_r};

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last && !q_valid) |=> (mask_r == '0))
    else $error("slots left after last triangle");

  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !last) |=> ($countones(mask_r) == $countones($past(mask_r)) - 1))
    else $error("emit did not retire exactly one slot");

  a_cell_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tlast_r) |-> have)
    else $error("non-final word with no triangles pending");

endmodule

FILE: src/marching_tetrahedra_cell_mesher.sv
// A cell word passes the queue, the cell registers and the output registers before
// its first triangle shows on out_*. One triangle word per cycle while out_tready is high;
// a cell with n triangles gives n words. Input takes a word every cycle while the 4-entry
// cell queue has room; cells with no crossing or outside the lattice are dropped at input.
// Reset (rst_n low, synchronous) empties the queue and clears all pending triangles.
module marching_tetrahedra_cell_mesher
  import mtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cell_x, cell_y, cell_z, corner_bits, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, pad
  output logic        out_tlast   // last_triangle
);

  logic     q_push, q_full, q_valid, q_pop;
  mtc_job_t wr_job, rd_job;

  mtc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (wr_job)
  );

  mtc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .rd_job (rd_job)
  );

  mtc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (rd_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
